// ===== design/pcg_random_source_top_assert.svh =====
// assertion macros for the random source top level
`ifndef PCG_RANDOM_SOURCE_TOP_ASSERT_SVH
`define PCG_RANDOM_SOURCE_TOP_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define PCG_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while in reset
`define PCG_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/pcg_pkg.sv =====
// shared types, constants and output permutation for the random source
package pcg_pkg;

   localparam int unsigned WORD_W  = 32;
   localparam int unsigned STATE_W = 64;

   localparam logic [STATE_W-1:0] LCG_MULT = 64'd6364136223846793005;
   localparam logic [STATE_W-1:0] LCG_INC  = 64'd1442695040888963407;

   localparam logic [1:0] OP_RAW     = 2'd0;
   localparam logic [1:0] OP_BOUNDED = 2'd1;
   localparam logic [1:0] OP_HALF    = 2'd2;
   localparam logic [1:0] OP_BYTE    = 2'd3;

   typedef struct packed {
      logic [1:0]        opcode;
      logic [WORD_W-1:0] bound;
   } pcg_req_type;

   typedef struct packed {
      logic [WORD_W-1:0] value;
      logic              bad_bound;
   } pcg_rsp_type;

   typedef struct packed {
      logic              start;
      logic [WORD_W-1:0] dividend;
      logic [WORD_W-1:0] divisor;
   } pcg_mod_req_type;

   // xsh-rr permutation of the pre-advance state
   function automatic logic [WORD_W-1:0] pcg_output(input logic [STATE_W-1:0] old);
      logic [STATE_W-1:0]  xs;
      logic [WORD_W-1:0]   x;
      logic [4:0]          rot;
      logic [2*WORD_W-1:0] dbl;
      xs  = (old >> 18) ^ old;
      x   = xs[58:27];
      rot = old[63:59];
      dbl = {x, x} >> rot;
      return dbl[WORD_W-1:0];
   endfunction

endpackage

// ===== design/pcg_lcg.sv =====
// lcg advance unit: 64-bit state times multiplier plus increment on one shared 32x32 multiplier
module pcg_lcg (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [pcg_pkg::STATE_W-1:0]  state_in,
   output logic                         busy,
   output logic                         done,
   output logic [pcg_pkg::STATE_W-1:0]  result
);

   localparam int unsigned HW = pcg_pkg::WORD_W;

   logic [HW-1:0]               opnd_lo_ff, opnd_lo_in;
   logic [HW-1:0]               opnd_hi_ff, opnd_hi_in;
   logic [1:0]                  phase_ff, phase_in;
   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [pcg_pkg::STATE_W-1:0] prod_ff, prod_in;
   logic [pcg_pkg::STATE_W-1:0] acc_ff, acc_in;
   logic [HW-1:0]               mul_a, mul_b;
   logic [HW-1:0]               acc_hi_sum;

   always_comb begin
      case (phase_ff)
         2'd0: begin
            mul_a = opnd_lo_ff;
            mul_b = pcg_pkg::LCG_MULT[HW-1:0];
         end
         2'd1: begin
            mul_a = opnd_lo_ff;
            mul_b = pcg_pkg::LCG_MULT[2*HW-1:HW];
         end
         default: begin
            mul_a = opnd_hi_ff;
            mul_b = pcg_pkg::LCG_MULT[HW-1:0];
         end
      endcase
   end

   assign acc_hi_sum = acc_ff[2*HW-1:HW] + prod_ff[HW-1:0];

   always_comb begin
      opnd_lo_in = opnd_lo_ff;
      opnd_hi_in = opnd_hi_ff;
      phase_in   = phase_ff;
      busy_in    = busy_ff;
      done_in    = 1'b0;
      prod_in    = 64'(mul_a) * 64'(mul_b);
      acc_in     = acc_ff;
      if (start) begin
         opnd_lo_in = state_in[HW-1:0];
         opnd_hi_in = state_in[2*HW-1:HW];
         phase_in   = 2'd0;
         busy_in    = 1'b1;
      end else if (busy_ff) begin
         phase_in = phase_ff + 2'd1;
         case (phase_ff)
            2'd0: ;
            2'd1: acc_in = prod_ff + pcg_pkg::LCG_INC;
            2'd2: acc_in = {acc_hi_sum, acc_ff[HW-1:0]};
            default: begin
               acc_in  = {acc_hi_sum, acc_ff[HW-1:0]};
               busy_in = 1'b0;
               done_in = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         phase_ff <= 2'd0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         phase_ff <= phase_in;
      end
      opnd_lo_ff <= opnd_lo_in;
      opnd_hi_ff <= opnd_hi_in;
      prod_ff    <= prod_in;
      acc_ff     <= acc_in;
   end

   assign busy   = busy_ff;
   assign done   = done_ff;
   assign result = acc_ff;

endmodule

// ===== design/pcg_mod.sv =====
// bit-serial restoring remainder unit, one dividend bit a cycle
module pcg_mod (
   input  logic                         clock,
   input  logic                         reset,
   input  pcg_pkg::pcg_mod_req_type     req,
   output logic                         busy,
   output logic                         done,
   output logic [pcg_pkg::WORD_W-1:0]   remainder
);

   localparam int unsigned W  = pcg_pkg::WORD_W;
   localparam int unsigned CW = $clog2(W);

   logic [W-1:0]  dvd_ff, dvd_in;
   logic [W-1:0]  dsr_ff, dsr_in;
   logic [W-1:0]  rem_ff, rem_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [W:0]    trial;
   logic [W:0]    diff;

   assign trial = {rem_ff, dvd_ff[W-1]};
   assign diff  = trial - {1'b0, dsr_ff};

   always_comb begin
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         dvd_in  = req.dividend;
         dsr_in  = req.divisor;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[W-2:0], 1'b0};
         rem_in = (trial >= {1'b0, dsr_ff}) ? diff[W-1:0] : trial[W-1:0];
         cnt_in = cnt_ff + CW'(1);
         if (cnt_ff == CW'(W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
      rem_ff <= rem_in;
   end

   assign busy      = busy_ff;
   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

// ===== design/pcg_random_source_top.sv =====
// random source top level: sequencer, generator state and result register
// one request at a time; req_stall is high from acceptance until the result is loaded.
// raw, fresh half or fresh byte: one lcg step, then the result register and rsp_valid; the
// first draw after reset or a seed write adds one more lcg step for the seed transform.
// bounded: zero bound flags bad_bound; else remainder unit finds the rejection limit, lcg
// steps draw until one is accepted and it is reduced; owed halves and bytes skip the lcg.
// synchronous reset loads the state that a seed of zero gives and clears owed halves and bytes.
module pcg_random_source_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  pcg_pkg::pcg_req_type          req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output pcg_pkg::pcg_rsp_type          rsp_data,
   input  logic                          csr_wen,
   input  logic [pcg_pkg::STATE_W-1:0]   csr_wdata
);

   localparam int unsigned W = pcg_pkg::WORD_W;

   typedef enum logic [5:0] {
      ST_IDLE     = 6'b000001,
      ST_SEED     = 6'b000010,
      ST_DRAW     = 6'b000100,
      ST_LIMIT    = 6'b001000,
      ST_REDUCE   = 6'b010000,
      ST_WAIT_OUT = 6'b100000
   } state_type;

   state_type                   state_ff, state_in;
   logic [1:0]                  op_ff, op_in;
   logic [W-1:0]                bound_ff, bound_in;
   logic [W-1:0]                limit_ff, limit_in;
   logic [pcg_pkg::STATE_W-1:0] lcg_state_ff, lcg_state_in;
   logic                        seed_step_ff, seed_step_in;
   logic [W-1:0]                half_word_ff, half_word_in;
   logic                        half_pending_ff, half_pending_in;
   logic [W-1:0]                byte_word_ff, byte_word_in;
   logic [1:0]                  bytes_left_ff, bytes_left_in;
   logic [W-1:0]                res_value_ff, res_value_in;
   logic                        res_bad_ff, res_bad_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   pcg_pkg::pcg_rsp_type        rsp_data_ff, rsp_data_in;

   logic                        lcg_start, lcg_busy, lcg_done;
   logic [pcg_pkg::STATE_W-1:0] lcg_result;
   pcg_pkg::pcg_mod_req_type    mod_req;
   logic                        mod_busy, mod_done;
   logic [W-1:0]                mod_rem;
   logic [W-1:0]                draw_word;
   logic                        req_beat;

   pcg_lcg u_lcg (
      .clock    (clock),
      .reset    (reset),
      .start    (lcg_start),
      .state_in (lcg_state_in),
      .busy     (lcg_busy),
      .done     (lcg_done),
      .result   (lcg_result)
   );

   pcg_mod u_mod (
      .clock     (clock),
      .reset     (reset),
      .req       (mod_req),
      .busy      (mod_busy),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign req_beat  = req_valid && !req_stall;
   assign draw_word = pcg_pkg::pcg_output(lcg_state_ff);

   always_comb begin
      state_in        = state_ff;
      op_in           = op_ff;
      bound_in        = bound_ff;
      limit_in        = limit_ff;
      lcg_state_in    = lcg_state_ff;
      seed_step_in    = seed_step_ff;
      half_word_in    = half_word_ff;
      half_pending_in = half_pending_ff;
      byte_word_in    = byte_word_ff;
      bytes_left_in   = bytes_left_ff;
      res_value_in    = res_value_ff;
      res_bad_in      = res_bad_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_data_in     = rsp_data_ff;
      lcg_start       = 1'b0;
      mod_req         = '0;

      case (state_ff)
         ST_IDLE: begin
            if (csr_wen) begin
               // the seed transform is one lcg step from seed plus increment
               lcg_state_in = csr_wdata + pcg_pkg::LCG_INC;
               seed_step_in = 1'b1;
            end
            if (req_beat) begin
               op_in      = req_data.opcode;
               bound_in   = req_data.bound;
               res_bad_in = 1'b0;
               if (req_data.opcode == pcg_pkg::OP_BOUNDED && req_data.bound == '0) begin
                  res_value_in = '0;
                  res_bad_in   = 1'b1;
                  state_in     = ST_WAIT_OUT;
               end else if (req_data.opcode == pcg_pkg::OP_BOUNDED) begin
                  mod_req.start    = 1'b1;
                  mod_req.dividend = W'(0) - req_data.bound;
                  mod_req.divisor  = req_data.bound;
                  state_in         = ST_LIMIT;
               end else if (req_data.opcode == pcg_pkg::OP_HALF && half_pending_ff) begin
                  half_pending_in = 1'b0;
                  res_value_in    = {16'd0, half_word_ff[31:16]};
                  state_in        = ST_WAIT_OUT;
               end else if (req_data.opcode == pcg_pkg::OP_BYTE && bytes_left_ff != 2'd0) begin
                  byte_word_in  = byte_word_ff >> 8;
                  bytes_left_in = bytes_left_ff - 2'd1;
                  res_value_in  = {24'd0, byte_word_ff[15:8]};
                  state_in      = ST_WAIT_OUT;
               end else begin
                  lcg_start = 1'b1;
                  state_in  = seed_step_in ? ST_SEED : ST_DRAW;
               end
            end
         end
         ST_LIMIT: begin
            if (mod_done) begin
               limit_in  = mod_rem;
               lcg_start = 1'b1;
               state_in  = seed_step_ff ? ST_SEED : ST_DRAW;
            end
         end
         ST_SEED: begin
            if (lcg_done) begin
               lcg_state_in = lcg_result;
               seed_step_in = 1'b0;
               lcg_start    = 1'b1;
               state_in     = ST_DRAW;
            end
         end
         ST_DRAW: begin
            if (lcg_done) begin
               lcg_state_in = lcg_result;
               case (op_ff)
                  pcg_pkg::OP_RAW: begin
                     res_value_in = draw_word;
                     state_in     = ST_WAIT_OUT;
                  end
                  pcg_pkg::OP_BOUNDED: begin
                     if (draw_word < limit_ff) begin
                        // rejected, redraw from the advanced state
                        lcg_start = 1'b1;
                     end else begin
                        mod_req.start    = 1'b1;
                        mod_req.dividend = draw_word;
                        mod_req.divisor  = bound_ff;
                        state_in         = ST_REDUCE;
                     end
                  end
                  pcg_pkg::OP_HALF: begin
                     half_word_in    = draw_word;
                     half_pending_in = 1'b1;
                     res_value_in    = {16'd0, draw_word[15:0]};
                     state_in        = ST_WAIT_OUT;
                  end
                  default: begin
                     byte_word_in  = draw_word;
                     bytes_left_in = 2'd3;
                     res_value_in  = {24'd0, draw_word[7:0]};
                     state_in      = ST_WAIT_OUT;
                  end
               endcase
            end
         end
         ST_REDUCE: begin
            if (mod_done) begin
               res_value_in = mod_rem;
               state_in     = ST_WAIT_OUT;
            end
         end
         ST_WAIT_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.value     = res_value_ff;
               rsp_data_in.bad_bound = res_bad_ff;
               state_in              = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         lcg_state_ff    <= pcg_pkg::LCG_INC;
         seed_step_ff    <= 1'b1;
         half_word_ff    <= '0;
         half_pending_ff <= 1'b0;
         byte_word_ff    <= '0;
         bytes_left_ff   <= 2'd0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         lcg_state_ff    <= lcg_state_in;
         seed_step_ff    <= seed_step_in;
         half_word_ff    <= half_word_in;
         half_pending_ff <= half_pending_in;
         byte_word_ff    <= byte_word_in;
         bytes_left_ff   <= bytes_left_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      op_ff        <= op_in;
      bound_ff     <= bound_in;
      limit_ff     <= limit_in;
      res_value_ff <= res_value_in;
      res_bad_ff   <= res_bad_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`include "pcg_random_source_top_assert.svh"

   `PCG_ASSERT_NXT(a_busy_after_beat, clock, reset, req_beat,
                   state_ff != ST_IDLE, "block idle right after an accepted beat")
   `PCG_ASSERT_IMP(a_units_exclusive, clock, reset, lcg_busy, !mod_busy,
                   "lcg and remainder units busy together")
   `PCG_ASSERT_IMP(a_bounded_in_range, clock, reset,
                   state_ff == ST_WAIT_OUT && op_ff == pcg_pkg::OP_BOUNDED && !res_bad_ff,
                   res_value_ff < bound_ff, "bounded result not below bound")

endmodule
